// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`define CHS_NEVER(lbl, prop, msg) `CHS_ASSERT(lbl, !(prop), msg)

`endif

// ===== hw/rtl/chs_pkg.sv =====
package chs_pkg;

	localparam int CFG_IDX_W = 4;
	localparam int Q_DEPTH   = 2;
	localparam int Q_PTR_W   = 1;
	localparam int Q_CNT_W   = 2;

	typedef enum logic [1:0] {
		CMD_RESET  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_WRITE  = 2'd2,
		CMD_PARAMS = 2'd3
	} cmd_e;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_BAD   = 2'd1,
		STS_CROSS = 2'd2
	} status_e;

	typedef struct packed {
		logic        vld;
		logic [7:0]  drive;
		logic [10:0] cyls;
		logic [7:0]  heads;
		logic [5:0]  secs;
	} slot_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  drive;
		logic [7:0]  cyl_low;
		logic [7:0]  sector_cyl_high;
		logic [7:0]  head;
		logic [7:0]  count;
		logic [15:0] buffer_segment;
		logic [15:0] buffer_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        transfer;
		logic        is_write;
		logic [23:0] lba;
		logic [19:0] mem_addr;
		logic        last;
		logic [7:0]  param_max_cyl_low;
		logic [7:0]  param_sector_cyl;
		logic [7:0]  param_max_head;
		logic [1:0]  param_drive_count;
	} rsp_t;

	// classified request handed from front to back
	typedef struct packed {
		logic        run;
		logic [1:0]  status;
		logic        is_write;
		logic [23:0] lba;
		logic [15:0] seg;
		logic [15:0] off;
		logic [7:0]  count;
		logic [7:0]  p_cyl;
		logic [7:0]  p_sc;
		logic [7:0]  p_head;
		logic [1:0]  p_cnt;
	} job_t;

endpackage

// ===== hw/rtl/chs_front.sv =====
module chs_front #(
	parameter int NUM_DRIVES = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  chs_pkg::slot_t slots [NUM_DRIVES],
	input  logic          req_valid,
	output logic          req_stall,
	input  chs_pkg::req_t req,
	input  logic          q_full,
	output logic          push,
	output chs_pkg::job_t push_data
);
	import chs_pkg::*;

	logic v_s1, v_s2, v_s3;
	req_t req_s1;

	job_t        job_s2, job_s3;
	logic [17:0] prod_s2;
	logic [7:0]  hd_s2;
	logic [5:0]  nsec_s2;
	logic [5:0]  secm1_s2, secm1_s3;
	logic [23:0] prod_s3;

	logic        found, found_next;
	slot_t       hit;
	logic [7:0]  drv_next;
	logic [9:0]  cyl;
	logic [5:0]  sec;
	logic [10:0] maxc;
	logic        bad, over_track;
	job_t        job;

	assign req_stall = v_s1 | v_s2 | v_s3 | q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req_valid & ~req_stall;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// drive lookup, lowest slot wins
	assign drv_next = req_s1.drive + 8'd1;

	always_comb begin
		found      = 1'b0;
		found_next = 1'b0;
		hit        = '0;
		for (int i = NUM_DRIVES - 1; i >= 0; i--) begin
			if (slots[i].vld && slots[i].drive == req_s1.drive) begin
				found = 1'b1;
				hit   = slots[i];
			end
			if (slots[i].vld && slots[i].drive == drv_next) begin
				found_next = 1'b1;
			end
		end
	end

	assign cyl   = {req_s1.sector_cyl_high[7:6], req_s1.cyl_low};
	assign sec   = req_s1.sector_cyl_high[5:0];
	assign maxc  = hit.cyls - 11'd1;
	assign bad   = (sec == 6'd0) || ({1'b0, cyl} >= hit.cyls) ||
		(req_s1.head >= hit.heads) || (sec > hit.secs);
	assign over_track = ({3'b000, sec} + {1'b0, req_s1.count}) >
		({3'b000, hit.secs} + 9'd1);

	always_comb begin
		job          = '0;
		job.status   = STS_OK;
		job.is_write = (req_s1.cmd == CMD_WRITE);
		job.seg      = req_s1.buffer_segment;
		job.off      = req_s1.buffer_offset;
		job.count    = req_s1.count;
		unique case (cmd_e'(req_s1.cmd))
			CMD_RESET: begin
				job.status = STS_OK;
			end
			CMD_PARAMS: begin
				if (!found) begin
					job.status = STS_BAD;
				end else begin
					job.p_cyl  = maxc[7:0];
					job.p_sc   = {maxc[9:8], hit.secs};
					job.p_head = hit.heads - 8'd1;
					job.p_cnt  = found_next ? 2'd2 : 2'd1;
				end
			end
			CMD_READ, CMD_WRITE: begin
				if (!found || bad) begin
					job.status = STS_BAD;
				end else if (over_track) begin
					job.status = STS_CROSS;
				end else if (req_s1.count != 8'd0) begin
					job.run = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		job_s2   <= job;
		prod_s2  <= {8'd0, cyl} * {10'd0, hit.heads};
		hd_s2    <= req_s1.head;
		nsec_s2  <= hit.secs;
		secm1_s2 <= sec - 6'd1;
		job_s3   <= job_s2;
		secm1_s3 <= secm1_s2;
		prod_s3  <= ({6'd0, prod_s2} + {16'd0, hd_s2}) * {18'd0, nsec_s2};
	end

	assign push = v_s3;

	always_comb begin
		push_data     = job_s3;
		push_data.lba = prod_s3 + {18'd0, secm1_s3};
	end

endmodule

// ===== hw/rtl/chs_queue.sv =====
module chs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  chs_pkg::job_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output chs_pkg::job_t pop_data
);
	import chs_pkg::*;

	job_t               mem [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/chs_back.sv =====
module chs_back #(
	parameter int SECTOR_BYTES = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_not_empty,
	input  chs_pkg::job_t q_data,
	output logic          pop,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output chs_pkg::rsp_t rsp
);
	import chs_pkg::*;

	logic        active_q, out_valid_q;
	logic [7:0]  rem_q;
	job_t        cur_q;
	logic [23:0] lba_q;
	logic [15:0] off_q;
	rsp_t        out_q;
	logic        can_load, emit, is_last;
	logic [19:0] addr;

	assign pop      = ~active_q & q_not_empty;
	assign can_load = ~out_valid_q | ~rsp_stall;
	assign emit     = active_q & can_load;
	assign is_last  = ~cur_q.run | (rem_q == 8'd1);
	assign addr     = {cur_q.seg, 4'b0000} + {4'b0000, off_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			rem_q       <= '0;
		end else begin
			if (can_load) begin
				out_valid_q <= active_q;
			end
			if (pop) begin
				active_q <= 1'b1;
				rem_q    <= q_data.count;
			end else if (emit) begin
				rem_q <= rem_q - 8'd1;
				if (is_last) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_data;
			lba_q <= q_data.lba;
			off_q <= q_data.off;
		end else if (emit) begin
			lba_q <= lba_q + 24'd1;
			off_q <= off_q + 16'(SECTOR_BYTES);
		end
		if (emit) begin
			out_q.status            <= cur_q.status;
			out_q.transfer          <= cur_q.run;
			out_q.is_write          <= cur_q.is_write;
			out_q.lba               <= cur_q.run ? lba_q : '0;
			out_q.mem_addr          <= cur_q.run ? addr : '0;
			out_q.last              <= is_last;
			out_q.param_max_cyl_low <= cur_q.p_cyl;
			out_q.param_sector_cyl  <= cur_q.p_sc;
			out_q.param_max_head    <= cur_q.p_head;
			out_q.param_drive_count <= cur_q.p_cnt;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ===== hw/rtl/disk_chs_to_lba_translator_unit.sv =====
// Disk request translator: CHS address to LBA, one response beat per sector.
// Request channel (req_valid/req_stall/req): command, drive, BIOS-packed CHS,
// sector count and segment:offset buffer. Response channel (rsp_valid/
// rsp_stall/rsp): one beat per sector for a good read or write, carrying the
// LBA and the 20-bit buffer address, last set on the final beat; every other
// request answers with a single beat that has last set.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): drive geometry slots,
// always ready; write only while no request is in flight.
// A request passes the front's s1, s2 and s3 registers, the queue and the
// back's cur_q and out_q registers before its first response beat shows. The
// front (lookup, two multiplier stages) takes no new request while one is in
// its stages or the queue is full; the back pops the next job only once the
// current one's last beat is emitted, and a 2-entry queue lets the two overlap.
// Reset clears all slots to invalid and empties the pipeline and queue.
// A stalled response holds; the back stops, the queue fills and then
// req_stall rises.
module disk_chs_to_lba_translator_unit #(
	parameter int NUM_DRIVES   = 4,
	parameter int SECTOR_BYTES = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  chs_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output chs_pkg::rsp_t                 rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [chs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [33:0]                   cfg_data
);
	import chs_pkg::*;

	slot_t slot_q [NUM_DRIVES];
	logic  q_full, push, pop, q_not_empty;
	job_t  push_data, pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DRIVES; i++) begin
				slot_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_DRIVES; i++) begin
				if (cfg_valid && cfg_index == CFG_IDX_W'(i)) begin
					slot_q[i] <= slot_t'(cfg_data);
				end
			end
		end
	end

	chs_front #(
		.NUM_DRIVES(NUM_DRIVES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.slots    (slot_q),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.q_full   (q_full),
		.push     (push),
		.push_data(push_data)
	);

	chs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.not_empty(q_not_empty),
		.pop_data (pop_data)
	);

	chs_back #(
		.SECTOR_BYTES(SECTOR_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_not_empty(q_not_empty),
		.q_data     (pop_data),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

// ===== hw/rtl/chs_checker.sv =====
`include "assert_macros.svh"

module chs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input chs_pkg::rsp_t rsp
);
	import chs_pkg::*;

	// stalled beat holds
	`CHS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "rsp changed under stall")

	`CHS_NEVER(a_xfer_status, rsp_valid && rsp.transfer && rsp.status != STS_OK, "transfer beat with error status")

	`CHS_ASSERT(a_single_last, rsp_valid && !rsp.transfer |-> rsp.last && rsp.lba == 24'd0 && rsp.mem_addr == 20'd0, "non-transfer beat malformed")

	// a run continues on the very next cycle with the next LBA
	`CHS_ASSERT(a_run_next, $past(rsp_valid && !rsp_stall && rsp.transfer && !rsp.last) |-> rsp_valid && rsp.transfer && rsp.lba == 24'($past(rsp.lba) + 24'd1), "run broken")

endmodule

bind disk_chs_to_lba_translator_unit chs_checker u_chk (.*);
